FILE: hdl/tprd_pkg.sv
// ----------------------------------------------------------------------------
// tprd_pkg
// Shared types and constants for the track position record decoder.
// ----------------------------------------------------------------------------
package tprd_pkg;

	typedef enum logic [3:0] {
		PH_FLAGS = 4'd0,
		PH_BASE  = 4'd1,
		PH_TID   = 4'd2,
		PH_CNT   = 4'd3,
		PH_TIME  = 4'd4,
		PH_LAT   = 4'd5,
		PH_LON   = 4'd6,
		PH_ALT   = 4'd7,
		PH_DTF   = 4'd8,
		PH_LAP   = 4'd9,
		PH_PC    = 4'd10,
		PH_DONE  = 4'd11
	} phase_t;

	localparam logic [14:0] DELTA_TIME_MASK = 15'd32767;
	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified input byte passed from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} req_t;

	// One decoded result.
	typedef struct packed {
		logic [15:0]        team_id;
		logic [15:0]        moment_index;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic [31:0]        timestamp;
		logic signed [31:0] distance_to_finish;
		logic [7:0]         lap;
		logic signed [15:0] altitude;
		logic               last_of_team;
		logic               empty_team;
		logic               truncated;
	} res_t;

endpackage

FILE: hdl/track_position_record_decoder.sv
// ----------------------------------------------------------------------------
// track_position_record_decoder
// Each accepted byte is held in the queue; a result that it completes is
// registered in the parser's result register.
// Throughput: one byte per cycle; a two-entry queue feeds the parser and
// its single result register, so the intake stalls only when both fill.
// Reset: arst_n clears the queue, all parser state and the result valid.
// Decodes a big-endian track file one byte at a time into moment results.
// ----------------------------------------------------------------------------
module track_position_record_decoder
	import tprd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               final_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        team_id,
	output logic [15:0]        moment_index,
	output logic signed [31:0] latitude,
	output logic signed [31:0] longitude,
	output logic [31:0]        timestamp,
	output logic signed [31:0] distance_to_finish,
	output logic [7:0]         lap,
	output logic signed [15:0] altitude,
	output logic               last_of_team,
	output logic               empty_team,
	output logic               truncated
);

	req_t in_req, q_req;
	logic q_valid, q_ready;
	res_t res;

	assign in_req = '{data_byte: data_byte, first_byte: first_byte, final_byte: final_byte};

	tprd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	tprd_parser u_parser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign team_id            = res.team_id;
	assign moment_index       = res.moment_index;
	assign latitude           = res.latitude;
	assign longitude          = res.longitude;
	assign timestamp          = res.timestamp;
	assign distance_to_finish = res.distance_to_finish;
	assign lap                = res.lap;
	assign altitude           = res.altitude;
	assign last_of_team       = res.last_of_team;
	assign empty_team         = res.empty_team;
	assign truncated          = res.truncated;

endmodule

FILE: hdl/tprd_queue.sv
// ----------------------------------------------------------------------------
// tprd_queue
// Two-entry request queue decoupling the byte intake from the parser.
// ----------------------------------------------------------------------------
module tprd_queue
	import tprd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);

	req_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_req   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1) else $error("push lost");
	a_count_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 2'd1) else $error("pop lost");

endmodule

FILE: hdl/tprd_parser.sv
// ----------------------------------------------------------------------------
// tprd_parser
// Byte parser: accumulates fields, applies delta or absolute form, and
// registers one result per completed moment, empty team or truncated end.
// ----------------------------------------------------------------------------
module tprd_parser
	import tprd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	phase_t      phase_q;
	logic [3:0]  flags_q;
	logic [31:0] base_q;
	logic [15:0] team_q;
	logic [15:0] left_q;
	logic [15:0] cnt_q;
	logic [31:0] shift_q;
	logic [2:0]  nbytes_q;
	logic        delta_q;
	logic [31:0] lat_q;
	logic [31:0] lon_q;
	logic [31:0] ptime_q;
	logic [31:0] dist_q;
	logic [31:0] wtime_q;
	logic [15:0] walt_q;
	logic [7:0]  wlap_q;
	logic        res_valid_q;
	res_t        res_q;

	// next-state values
	phase_t      ph_n;
	logic [31:0] base_n, shift_n, lat_n, lon_n, ptime_n, dist_n, wtime_n;
	logic [15:0] team_n, left_n, cnt_n, walt_n;
	logic [7:0]  wlap_n;
	logic [3:0]  flags_n;
	logic [2:0]  nbytes_n, flen;
	logic        delta_n, emit;
	res_t        r;
	phase_t      cur;
	logic [31:0] v, sx;
	logic        take;

	assign take      = in_valid && in_ready;
	assign in_ready  = !res_valid_q || out_ready;
	assign out_valid = res_valid_q;
	assign out_res   = res_q;

	function automatic logic present(phase_t p, logic [3:0] f);
		case (p)
			PH_ALT:  present = f[0];
			PH_DTF:  present = f[1];
			PH_LAP:  present = f[1] && f[2];
			PH_PC:   present = f[3];
			default: present = 1'b1;
		endcase
	endfunction

	function automatic phase_t adv(phase_t p, logic [3:0] f);
		phase_t q;
		q = p;
		if (q == PH_ALT && !present(PH_ALT, f)) q = PH_DTF;
		if (q == PH_DTF && !present(PH_DTF, f)) q = PH_LAP;
		if (q == PH_LAP && !present(PH_LAP, f)) q = PH_PC;
		if (q == PH_PC && !present(PH_PC, f)) q = PH_DONE;
		return q;
	endfunction

	always_comb begin
		ph_n = phase_q; flags_n = flags_q; base_n = base_q; team_n = team_q;
		left_n = left_q; cnt_n = cnt_q; shift_n = shift_q; nbytes_n = nbytes_q;
		delta_n = delta_q; lat_n = lat_q; lon_n = lon_q; ptime_n = ptime_q;
		dist_n = dist_q; wtime_n = wtime_q; walt_n = walt_q; wlap_n = wlap_q;
		r = '0; emit = 1'b0; v = '0; sx = '0; flen = 3'd4;
		cur = in_req.first_byte ? PH_FLAGS : phase_q;
		if (in_req.first_byte) begin
			nbytes_n = 3'd0; shift_n = '0;
		end
		if (cur == PH_FLAGS) begin
			flags_n = in_req.data_byte[3:0];
			ph_n = PH_BASE; nbytes_n = 3'd0; shift_n = '0;
		end else if (cur <= PH_PC) begin
			if (cur == PH_TIME && nbytes_n == 3'd0) begin
				delta_n = in_req.data_byte[7]; walt_n = '0; wlap_n = '0;
			end
			v = {shift_n[23:0], in_req.data_byte};
			nbytes_n = nbytes_n + 3'd1;
			case (cur)
				PH_BASE:                flen = 3'd4;
				PH_TID, PH_CNT, PH_ALT: flen = 3'd2;
				PH_LAP:                 flen = 3'd1;
				default:                flen = delta_n ? 3'd2 : 3'd4;
			endcase
			shift_n = v;
			sx = {{16{v[15]}}, v[15:0]};
			if (nbytes_n >= flen) begin
				nbytes_n = 3'd0; shift_n = '0;
				case (cur)
					PH_BASE: begin
						base_n = v; ph_n = PH_TID;
					end
					PH_TID: begin
						team_n = v[15:0]; ph_n = PH_CNT;
					end
					PH_CNT: begin
						if (v[15:0] == 16'd0) begin
							r.team_id = team_q; r.empty_team = 1'b1; emit = 1'b1;
							ph_n = PH_TID;
						end else begin
							left_n = v[15:0]; cnt_n = '0;
							lat_n = '0; lon_n = '0; ptime_n = '0; dist_n = '0;
							ph_n = PH_TIME;
						end
					end
					default: begin
						case (cur)
							PH_TIME: wtime_n = delta_n ?
								ptime_q - {17'd0, v[14:0] & DELTA_TIME_MASK} : base_q + v;
							PH_LAT:  lat_n = delta_n ? lat_q + sx : v;
							PH_LON:  lon_n = delta_n ? lon_q + sx : v;
							PH_ALT:  walt_n = v[15:0];
							PH_DTF:  dist_n = delta_n ? dist_q + sx : v;
							PH_LAP:  wlap_n = v[7:0];
							default: ;
						endcase
						ph_n = adv(phase_t'(cur + 4'd1), flags_q);
						if (ph_n == PH_DONE) begin
							if (!flags_q[1]) dist_n = '0;
							ptime_n = wtime_n;
							left_n = left_q - 16'd1;
							r.team_id = team_q;
							r.moment_index = cnt_q;
							r.latitude = lat_n;
							r.longitude = lon_n;
							r.timestamp = wtime_n;
							r.distance_to_finish = dist_n;
							r.lap = wlap_n;
							r.altitude = walt_n;
							r.last_of_team = (left_n == 16'd0);
							emit = 1'b1;
							cnt_n = cnt_q + 16'd1;
							ph_n = (left_n == 16'd0) ? PH_TID : PH_TIME;
						end
					end
				endcase
			end
		end else begin
			ph_n = PH_FLAGS;
		end
		if (in_req.final_byte) begin
			if (!(ph_n == PH_TID && nbytes_n == 3'd0)) begin
				r.truncated = 1'b1; emit = 1'b1;
			end
			ph_n = PH_FLAGS; nbytes_n = 3'd0; shift_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS; flags_q <= '0; base_q <= '0; team_q <= '0;
			left_q <= '0; cnt_q <= '0; shift_q <= '0; nbytes_q <= '0;
			delta_q <= 1'b0; lat_q <= '0; lon_q <= '0; ptime_q <= '0;
			dist_q <= '0; wtime_q <= '0; walt_q <= '0; wlap_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_ready) res_valid_q <= 1'b0;
			if (take) begin
				phase_q <= ph_n; flags_q <= flags_n; base_q <= base_n; team_q <= team_n;
				left_q <= left_n; cnt_q <= cnt_n; shift_q <= shift_n;
				nbytes_q <= nbytes_n; delta_q <= delta_n; lat_q <= lat_n;
				lon_q <= lon_n; ptime_q <= ptime_n; dist_q <= dist_n;
				wtime_q <= wtime_n; walt_q <= walt_n; wlap_q <= wlap_n;
				if (emit) res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) res_q <= r;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_res))
		else $error("result dropped");
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_req.final_byte) |=> phase_q == PH_FLAGS)
		else $error("final byte left parse open");
	a_nbytes: assert property (@(posedge clk) disable iff (!arst_n)
		nbytes_q < 3'd4) else $error("field byte count overrun");

endmodule

FILE: test/track_position_record_decoder_check.sv
// ----------------------------------------------------------------------------
// track_position_record_decoder_check
// Watches both channels of the decoder, predicts the results of the accepted
// requests from its own copy of the parser state and compares field by field.
// ----------------------------------------------------------------------------
module track_position_record_decoder_check
	import tprd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               final_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [15:0]        team_id,
	input  logic [15:0]        moment_index,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic [31:0]        timestamp,
	input  logic signed [31:0] distance_to_finish,
	input  logic [7:0]         lap,
	input  logic signed [15:0] altitude,
	input  logic               last_of_team,
	input  logic               empty_team,
	input  logic               truncated,
	output int                 fail_count,
	output int                 pending
);

	phase_t      phase;
	logic [3:0]  flags;
	logic [31:0] base, acc, lat_sum, lon_sum, time_prev, dist_sum, time_work;
	logic [15:0] team, left, index;
	logic [15:0] alt_work;
	logic [7:0]  lap_work;
	logic [2:0]  nbytes;
	logic        delta;
	res_t        moments_due[$];

	assign pending = moments_due.size();

	function automatic logic has_field(phase_t p);
		case (p)
			PH_ALT:  return flags[0];
			PH_DTF:  return flags[1];
			PH_LAP:  return flags[1] && flags[2];
			PH_PC:   return flags[3];
			default: return 1'b1;
		endcase
	endfunction

	function automatic logic [2:0] width_of(phase_t p);
		case (p)
			PH_BASE:                return 3'd4;
			PH_TID, PH_CNT, PH_ALT: return 3'd2;
			PH_LAP:                 return 3'd1;
			default:                return delta ? 3'd2 : 3'd4;
		endcase
	endfunction

	function automatic logic [31:0] sx16(logic [31:0] v);
		return {{16{v[15]}}, v[15:0]};
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic fst, input logic fin);
		res_t        r;
		logic        got;
		logic [31:0] v;
		phase_t      p;
		r = '0;
		got = 1'b0;
		if (fst) begin
			phase = PH_FLAGS;
			nbytes = 0;
			acc = 0;
		end
		if (phase == PH_FLAGS) begin
			flags = b[3:0];
			phase = PH_BASE;
			nbytes = 0;
			acc = 0;
		end else if (phase <= PH_PC) begin
			if (phase == PH_TIME && nbytes == 0) begin
				delta = b[7];
				alt_work = 0;
				lap_work = 0;
			end
			acc = {acc[23:0], b};
			nbytes = nbytes + 3'd1;
			if (nbytes >= width_of(phase)) begin
				v = acc;
				nbytes = 0;
				acc = 0;
				case (phase)
					PH_BASE: begin
						base = v;
						phase = PH_TID;
					end
					PH_TID: begin
						team = v[15:0];
						phase = PH_CNT;
					end
					PH_CNT: begin
						if (v[15:0] == 0) begin
							r.team_id = team;
							r.empty_team = 1'b1;
							got = 1'b1;
							phase = PH_TID;
						end else begin
							left = v[15:0];
							index = 0;
							lat_sum = 0;
							lon_sum = 0;
							time_prev = 0;
							dist_sum = 0;
							phase = PH_TIME;
						end
					end
					default: begin
						case (phase)
							PH_TIME: time_work = delta ? time_prev - {17'd0, v[14:0]} : base + v;
							PH_LAT:  lat_sum = delta ? lat_sum + sx16(v) : v;
							PH_LON:  lon_sum = delta ? lon_sum + sx16(v) : v;
							PH_ALT:  alt_work = v[15:0];
							PH_DTF:  dist_sum = delta ? dist_sum + sx16(v) : v;
							PH_LAP:  lap_work = v[7:0];
							default: ;
						endcase
						p = phase_t'(phase + 1);
						while (p < PH_DONE && !has_field(p))
							p = phase_t'(p + 1);
						phase = p;
						if (phase == PH_DONE) begin
							if (!flags[1])
								dist_sum = 0;
							time_prev = time_work;
							left = left - 16'd1;
							r.team_id = team;
							r.moment_index = index;
							r.latitude = lat_sum;
							r.longitude = lon_sum;
							r.timestamp = time_work;
							r.distance_to_finish = dist_sum;
							r.lap = lap_work;
							r.altitude = alt_work;
							r.last_of_team = (left == 0);
							got = 1'b1;
							index = index + 16'd1;
							phase = (left == 0) ? PH_TID : PH_TIME;
						end
					end
				endcase
			end
		end else begin
			phase = PH_FLAGS;
		end
		if (fin) begin
			if (!(phase == PH_TID && nbytes == 0)) begin
				r.truncated = 1'b1;
				got = 1'b1;
			end
			phase = PH_FLAGS;
			nbytes = 0;
			acc = 0;
		end
		if (got)
			moments_due.push_back(r);
	endtask

	task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", what, seen, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			phase = PH_FLAGS;
			flags = 0; base = 0; acc = 0; lat_sum = 0; lon_sum = 0;
			time_prev = 0; dist_sum = 0; time_work = 0; team = 0; left = 0;
			index = 0; alt_work = 0; lap_work = 0; nbytes = 0; delta = 0;
			moments_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (moments_due.size() == 0) begin
					$display("unexpected result from team %h", team_id);
					fail_count++;
				end else begin
					e = moments_due.pop_front();
					if (team_id !== e.team_id)
						report("team_id", team_id, e.team_id);
					if (moment_index !== e.moment_index)
						report("moment_index", moment_index, e.moment_index);
					if (latitude !== e.latitude)
						report("latitude", latitude, e.latitude);
					if (longitude !== e.longitude)
						report("longitude", longitude, e.longitude);
					if (timestamp !== e.timestamp)
						report("timestamp", timestamp, e.timestamp);
					if (distance_to_finish !== e.distance_to_finish)
						report("distance_to_finish", distance_to_finish,
							e.distance_to_finish);
					if (lap !== e.lap)
						report("lap", lap, e.lap);
					if (altitude !== e.altitude)
						report("altitude", altitude, e.altitude);
					if (last_of_team !== e.last_of_team)
						report("last_of_team", last_of_team, e.last_of_team);
					if (empty_team !== e.empty_team)
						report("empty_team", empty_team, e.empty_team);
					if (truncated !== e.truncated)
						report("truncated", truncated, e.truncated);
				end
			end
			if (in_valid && in_ready)
				decode_byte(data_byte, first_byte, final_byte);
		end
	end

endmodule

FILE: test/track_position_record_decoder_test.sv
// ----------------------------------------------------------------------------
// track_position_record_decoder_test
// Feeds the decoder with whole track files of random content, mostly well
// formed, plus restarts, truncations and noise, under random gaps and stalls.
// ----------------------------------------------------------------------------
module track_position_record_decoder_test;
	import tprd_pkg::*;

	logic               clk, arst_n;
	logic               in_valid, in_ready;
	logic [7:0]         data_byte;
	logic               first_byte, final_byte;
	logic               out_valid, out_ready;
	logic [15:0]        team_id, moment_index;
	logic signed [31:0] latitude, longitude, distance_to_finish;
	logic [31:0]        timestamp;
	logic [7:0]         lap;
	logic signed [15:0] altitude;
	logic               last_of_team, empty_team, truncated;
	int                 fail_count, pending, sent, cycles;
	int                 burst, stall_mode;

	localparam int CYCLE_LIMIT = 200000;

	track_position_record_decoder dut (.*);
	track_position_record_decoder_check check (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= cycles[2];
		endcase
		if ($urandom_range(0, 99) == 0)
			stall_mode <= $urandom_range(0, 3);
	end

	// valid drops only at the start of a gap, so back-to-back requests keep it high
	task automatic put(input logic [7:0] b, input logic fst = 1'b0, input logic fin = 1'b0);
		if (burst == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
		end else
			burst--;
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= fst;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic put_bytes(input logic [31:0] v, input int n, input logic fin = 1'b0);
		for (int i = n - 1; i >= 0; i--)
			put(v[8 * i +: 8], 1'b0, fin && i == 0);
	endtask

	function automatic int rec_len(logic [3:0] f, logic dl);
		int n;
		n = dl ? 6 : 12;
		if (f[0]) n += 2;
		if (f[1]) n += dl ? 2 : 4;
		if (f[1] && f[2]) n += 1;
		if (f[3]) n += dl ? 2 : 4;
		return n;
	endfunction

	// One file; cut > 0 ends it early after that many bytes of body.
	task automatic send_file(input logic [3:0] f, input int teams, input int cut);
		int     body, n, len;
		logic   dl;
		logic [31:0] w;
		body = 0;
		put({4'($urandom_range(0, 15)), f}, 1'b1, 1'b0);
		put_bytes($urandom, 4);
		for (int t = 0; t < teams; t++) begin
			n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
			put_bytes($urandom, 2);
			put_bytes(n, 2, (t == teams - 1) && n == 0);
			for (int m = 0; m < n; m++) begin
				dl = 1'($urandom_range(0, 1));
				len = rec_len(f, dl);
				for (int k = 0; k < len; k++) begin
					w = $urandom;
					if (k == 0) w[7] = dl;
					body++;
					if (cut > 0 && body == cut) begin
						put(w[7:0], 1'b0, 1'b1);
						return;
					end
					put(w[7:0], 1'b0,
						(t == teams - 1) && m == n - 1 && k == len - 1);
				end
			end
		end
		if (teams == 0) put(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0; data_byte = 0; first_byte = 0; final_byte = 0;
		out_ready = 1; cycles = 0; sent = 0; burst = 0; stall_mode = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, every flag, empty team, restart, truncation, noise
		put(8'hFF, 1'b1); put_bytes(32'hFFFF_FFFF, 4); put_bytes(16'hFFFF, 2);
		put_bytes(16'd0, 2, 1'b1);
		send_file(4'hF, 1, 0);
		send_file(4'h0, 1, 0);
		send_file(4'h6, 1, 3);
		put(8'h00, 1'b1); put_bytes(32'h0, 2); put(8'h03, 1'b1); put_bytes(32'h0, 4);
		put(8'h55, 1'b0, 1'b1);
		put(8'hA5, 1'b0, 1'b1);
		// random: mostly whole files, some truncated, some noise
		while (sent < 1150) begin
			if ($urandom_range(0, 9) == 0)
				put(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else
				send_file(4'($urandom), $urandom_range(1, 3),
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 0);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
